[hw/rtl/matrix_multiply_engine_assert.svh]
// ----------------------------------------------------------------------------
// Matrix multiply engine assertion macros
// Shared property forms for the checker of the matrix multiply engine.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ENGINE_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define MME_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define MME_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/mme_pkg.sv]
// ----------------------------------------------------------------------------
// Matrix multiply engine package
// Field widths, operation and register codes and shared types.
// ----------------------------------------------------------------------------
package mme_pkg;

    // Parameter defaults
    localparam int MAX_DIM_DEFAULT    = 64;
    localparam int ELEM_WIDTH_DEFAULT = 16;

    // Field widths
    localparam int FUNC_W      = 2;
    localparam int ROW_W       = 6;
    localparam int VALUE_W     = 16;
    localparam int DIM_W       = 7;
    localparam int OUT_VALUE_W = 38;
    localparam int CFG_INDEX_W = 2;

    // Stream packing
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * ROW_W - OUT_VALUE_W;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Dimension register reset value
    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    // Operation codes, shared by the func field and the queue entries
    typedef logic [FUNC_W-1:0] op_t;
    localparam op_t OP_LOAD_A  = 2'd0;
    localparam op_t OP_LOAD_B  = 2'd1;
    localparam op_t OP_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS_M  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLS_N  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INNER_K = 2'd2;

    // Clamped dimensions handed from front to back
    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
        logic [DIM_W-1:0] inner;
    } dims_t;

    // Limit a dimension register to the store size
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int cap);
        return (int'(v) > cap) ? DIM_W'(cap) : v;
    endfunction

endpackage

[hw/rtl/matrix_multiply_engine.sv]
// ----------------------------------------------------------------------------
// Matrix multiply engine
// Row-at-a-time C = A x B over signed Q8.8 operands with exact Q22.16 sums.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries input items: tuser is func (0 load A, 1 load B, 2 compute
//   row of C); tdata holds row, col and the Q8.8 value. Loads write one
//   element of A or B; a compute item for row i returns cols_n items on
//   m_axis, one per column in order, with tlast on the final column.
//   cfg_* writes rows_m (index 0), cols_n (1) and inner_k (2); write them only
//   while the engine is idle.
// Operation:
//   A load writes its element into A or B as it leaves the queue. A compute
//   item holds the back while the single MAC unit steps through max(inner_k, 1)
//   products for each of the cols_n columns; the back takes no new item until
//   the whole row is issued. Items queue (four deep) meanwhile.
// Reset and stalls:
//   Reset sets all three dimensions to 64 and empties the queue and pipeline;
//   the operand stores are not cleared and must be loaded before use.
//   When m_axis_tready is low with a result held, the MAC pipeline freezes;
//   the input side keeps taking items until the queue fills.
// ----------------------------------------------------------------------------
module matrix_multiply_engine #(
    parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEFAULT,
    parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // tdata: row[5:0], col[11:6], value[27:12], zero pad[31:28]
    input  logic [mme_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: func[1:0]
    input  logic [mme_pkg::FUNC_W-1:0]      s_axis_tuser,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: out_row[5:0], out_col[11:6], out_value[49:12], zero pad[55:50]
    output logic [mme_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mme_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mme_pkg::DIM_W-1:0]       cfg_data
);

    import mme_pkg::*;

    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
    localparam int Q_W    = FUNC_W + ROW_W + ADDR_W + ELEM_WIDTH;

    logic           q_push;
    logic [Q_W-1:0] q_push_data;
    logic           q_full;
    logic           q_pop;
    logic [Q_W-1:0] q_pop_data;
    logic           q_empty;
    dims_t          dims;

    // Accept and classify
    mme_front #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mme_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_push_data),
        .dims          (dims)
    );

    // Decouple front and back
    mme_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_mme_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // Execute loads and row requests
    mme_back #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mme_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .q_data        (q_pop_data),
        .dims          (dims),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[hw/rtl/mme_ram.sv]
// ----------------------------------------------------------------------------
// Matrix multiply engine RAM
// Generic single write, single read memory with registered read data.
// ----------------------------------------------------------------------------
module mme_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 4096,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/mme_queue.sv]
// ----------------------------------------------------------------------------
// Matrix multiply engine queue
// Short first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module mme_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/mme_front.sv]
// ----------------------------------------------------------------------------
// Matrix multiply engine front
// Accepts input items, holds the dimension registers, drops items that do
// nothing and queues loads and row requests for the back.
// ----------------------------------------------------------------------------
module mme_front #(
    parameter  int MAX_DIM    = 64,
    parameter  int ELEM_WIDTH = 16,
    localparam int ADDR_W     = $clog2(MAX_DIM * MAX_DIM),
    localparam int Q_W        = mme_pkg::FUNC_W + mme_pkg::ROW_W + ADDR_W + ELEM_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mme_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic [mme_pkg::FUNC_W-1:0]         s_axis_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mme_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mme_pkg::DIM_W-1:0]          cfg_data,
    input  logic                               q_full,
    output logic                               q_push,
    output logic [Q_W-1:0]                     q_data,
    output mme_pkg::dims_t                     dims
);

    import mme_pkg::*;

    localparam logic [ADDR_W-1:0] DIM_MUL = ADDR_W'(MAX_DIM);

    logic [DIM_W-1:0]        rows_m_reg, rows_m_next;
    logic [DIM_W-1:0]        cols_n_reg, cols_n_next;
    logic [DIM_W-1:0]        inner_k_reg, inner_k_next;
    op_t                     func;
    logic [ROW_W-1:0]        row;
    logic [ROW_W-1:0]        col;
    logic signed [VALUE_W-1:0] value;
    logic [ELEM_WIDTH-1:0]   elem;
    logic                    load_ok;
    logic                    comp_ok;
    logic                    useful;
    logic [ADDR_W-1:0]       addr;

    assign cfg_ready = 1'b1;

    // Register writes
    always_comb
    begin
        rows_m_next  = rows_m_reg;
        cols_n_next  = cols_n_reg;
        inner_k_next = inner_k_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ROWS_M:  rows_m_next  = cfg_data;
                REG_COLS_N:  cols_n_next  = cfg_data;
                REG_INNER_K: inner_k_next = cfg_data;
                default:     rows_m_next  = rows_m_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m_reg  <= DIM_RESET;
            cols_n_reg  <= DIM_RESET;
            inner_k_reg <= DIM_RESET;
        end
        else
        begin
            rows_m_reg  <= rows_m_next;
            cols_n_reg  <= cols_n_next;
            inner_k_reg <= inner_k_next;
        end
    end

    // Limit dimensions to the store size
    assign dims.rows  = clamp_dim(rows_m_reg, MAX_DIM);
    assign dims.cols  = clamp_dim(cols_n_reg, MAX_DIM);
    assign dims.inner = clamp_dim(inner_k_reg, MAX_DIM);

    // Unpack the item
    assign func  = s_axis_tuser;
    assign row   = s_axis_tdata[ROW_W-1:0];
    assign col   = s_axis_tdata[2*ROW_W-1:ROW_W];
    assign value = signed'(s_axis_tdata[2*ROW_W+VALUE_W-1:2*ROW_W]);
    assign elem  = ELEM_WIDTH'(value);

    // Classify: keep in-range loads and row requests that give results
    assign load_ok = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
    assign comp_ok = ({1'b0, row} < dims.rows) && (dims.cols != '0);

    always_comb
    begin
        case (func)
            OP_LOAD_A, OP_LOAD_B:
            begin
                useful = load_ok;
                addr   = ADDR_W'(row) * DIM_MUL + ADDR_W'(col);
            end
            OP_COMPUTE:
            begin
                useful = comp_ok;
                addr   = ADDR_W'(row) * DIM_MUL;
            end
            default:
            begin
                useful = 1'b0;
                addr   = '0;
            end
        endcase
    end

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && s_axis_tready && useful;
    assign q_data        = {func, row, addr, elem};

endmodule

[hw/rtl/mme_back.sv]
// ----------------------------------------------------------------------------
// Matrix multiply engine back
// Writes loaded elements into the operand stores and walks each row request
// through a read, multiply and accumulate pipeline into the output register.
// ----------------------------------------------------------------------------
module mme_back #(
    parameter  int MAX_DIM    = 64,
    parameter  int ELEM_WIDTH = 16,
    localparam int ADDR_W     = $clog2(MAX_DIM * MAX_DIM),
    localparam int Q_W        = mme_pkg::FUNC_W + mme_pkg::ROW_W + ADDR_W + ELEM_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    output logic                            q_pop,
    input  logic [Q_W-1:0]                  q_data,
    input  mme_pkg::dims_t                  dims,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [mme_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);

    import mme_pkg::*;

    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam logic [ADDR_W-1:0] DIM_MUL = ADDR_W'(MAX_DIM);

    typedef struct packed {
        logic             valid;
        logic             mac;
        logic             first;
        logic             last_t;
        logic             last_c;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
    } beat_t;

    op_t                      q_op;
    logic [ROW_W-1:0]         q_row;
    logic [ADDR_W-1:0]        q_addr;
    logic [ELEM_WIDTH-1:0]    q_elem;
    logic                     start;
    logic                     adv;
    logic                     issue;
    logic                     last_t0;
    logic                     last_c0;
    logic [ADDR_W-1:0]        a_raddr;
    logic [ADDR_W-1:0]        b_raddr;
    logic [ELEM_WIDTH-1:0]    a_rdata;
    logic [ELEM_WIDTH-1:0]    b_rdata;
    logic signed [PROD_W-1:0] prod;
    logic [OUT_VALUE_W-1:0]   acc_next;
    logic                     emit;
    beat_t                    beat0;

    logic                     busy_reg, busy_next;
    logic [DIM_W-1:0]         t_reg, t_next;
    logic [DIM_W-1:0]         j_reg, j_next;
    logic [ROW_W-1:0]         row_reg, row_next;
    logic [ADDR_W-1:0]        base_reg, base_next;
    beat_t                    s1_reg, s2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [OUT_VALUE_W-1:0]   acc_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0]   out_data_reg;
    logic                     out_last_reg;

    // Unpack the queue head
    assign q_op   = q_data[Q_W-1 -: FUNC_W];
    assign q_row  = q_data[ADDR_W+ELEM_WIDTH +: ROW_W];
    assign q_addr = q_data[ELEM_WIDTH +: ADDR_W];
    assign q_elem = q_data[ELEM_WIDTH-1:0];

    // Take the next item once the current row has been issued
    assign q_pop = !q_empty && !busy_reg;
    assign start = q_pop && (q_op == OP_COMPUTE);

    // Whole pipeline moves while the output register can take a result
    assign adv   = !out_valid_reg || m_axis_tready;
    assign issue = busy_reg && adv;

    // Current beat of the row walk
    assign last_t0 = (dims.inner == '0) || (t_reg == dims.inner - 1'b1);
    assign last_c0 = (j_reg == dims.cols - 1'b1);
    assign a_raddr = base_reg + ADDR_W'(t_reg);
    assign b_raddr = ADDR_W'(t_reg) * DIM_MUL + ADDR_W'(j_reg);

    always_comb
    begin
        beat0.valid  = issue;
        beat0.mac    = (dims.inner != '0);
        beat0.first  = (t_reg == '0);
        beat0.last_t = last_t0;
        beat0.last_c = last_c0;
        beat0.row    = row_reg;
        beat0.col    = ROW_W'(j_reg);
    end

    // Operand stores
    mme_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_a_ram (
        .clk   (clk),
        .we    (q_pop && (q_op == OP_LOAD_A)),
        .waddr (q_addr),
        .wdata (q_elem),
        .re    (issue && beat0.mac),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mme_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_b_ram (
        .clk   (clk),
        .we    (q_pop && (q_op == OP_LOAD_B)),
        .waddr (q_addr),
        .wdata (q_elem),
        .re    (issue && beat0.mac),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // Step the inner and column counters
    always_comb
    begin
        busy_next = busy_reg;
        t_next    = t_reg;
        j_next    = j_reg;
        row_next  = row_reg;
        base_next = base_reg;
        if (start)
        begin
            busy_next = 1'b1;
            t_next    = '0;
            j_next    = '0;
            row_next  = q_row;
            base_next = q_addr;
        end
        else if (issue)
        begin
            if (last_t0)
            begin
                t_next = '0;
                if (last_c0)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            else
            begin
                t_next = t_reg + 1'b1;
            end
        end
    end

    // Multiply the operands, zero for an empty inner dimension
    assign prod = s1_reg.mac ? (PROD_W'(signed'(a_rdata)) * PROD_W'(signed'(b_rdata)))
                             : '0;

    // Accumulate, restarting on the first beat of each column
    assign acc_next = (s2_reg.first ? '0 : acc_reg) + OUT_VALUE_W'(prod_reg);
    assign emit     = adv && s2_reg.valid && s2_reg.last_t;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            t_reg         <= '0;
            j_reg         <= '0;
            s1_reg        <= '0;
            s2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            t_reg         <= t_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                s1_reg <= beat0;
                s2_reg <= s1_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        base_reg <= base_next;
        if (adv)
        begin
            prod_reg <= prod;
            if (s2_reg.valid)
            begin
                acc_reg <= acc_next;
            end
        end
        if (emit)
        begin
            out_data_reg <= {OUT_PAD_W'(0), acc_next, s2_reg.col, s2_reg.row};
            out_last_reg <= s2_reg.last_c;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

[hw/rtl/mme_checker.sv]
// ----------------------------------------------------------------------------
// Matrix multiply engine checker
// Watches the result stream: held items under stall and row/column order.
// ----------------------------------------------------------------------------
`include "matrix_multiply_engine_assert.svh"

module mme_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic [mme_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready
);

    import mme_pkg::*;

    logic             out_acc;
    logic [ROW_W-1:0] out_row;
    logic [ROW_W-1:0] out_col;
    logic [ROW_W-1:0] exp_col_reg, exp_col_next;
    logic [ROW_W-1:0] run_row_reg, run_row_next;
    logic             in_run_reg, in_run_next;

    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign out_row = m_axis_tdata[ROW_W-1:0];
    assign out_col = m_axis_tdata[2*ROW_W-1:ROW_W];

    // Track position within the current row of results
    always_comb
    begin
        exp_col_next = exp_col_reg;
        run_row_next = run_row_reg;
        in_run_next  = in_run_reg;
        if (out_acc)
        begin
            exp_col_next = m_axis_tlast ? '0 : out_col + 1'b1;
            run_row_next = out_row;
            in_run_next  = !m_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_col_reg <= '0;
            run_row_reg <= '0;
            in_run_reg  <= 1'b0;
        end
        else
        begin
            exp_col_reg <= exp_col_next;
            run_row_reg <= run_row_next;
            in_run_reg  <= in_run_next;
        end
    end

    `MME_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result item changed")
    `MME_ASSERT_SAME(a_col_order, clk, rst_n, out_acc, out_col == exp_col_reg, "result column out of order")
    `MME_ASSERT_SAME(a_row_steady, clk, rst_n, out_acc && in_run_reg, out_row == run_row_reg, "result row changed within a row")

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
